/* hdl/sti_pkg.sv */
package sti_pkg;

  localparam int DEFAULT_DEPTH = 16;
  localparam int VALUE_W       = 32;

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [1:0]                cmd;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] position;
    logic [4:0] entry_count;
  } out_item_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      ins_en;
    logic                      del_en;
  } cell_ctl_t;

endpackage

/* hdl/sti_cell.sv */
module sti_cell #(
  parameter int DEPTH = sti_pkg::DEFAULT_DEPTH,
  parameter int IDX   = 0
) (
  input  logic                                  clk,
  input  sti_pkg::cell_ctl_t                    ctl,
  input  logic [$clog2(DEPTH+1)-1:0]            count,
  input  logic                                  left_less,
  input  logic signed [sti_pkg::VALUE_W-1:0]    left_entry,
  input  logic signed [sti_pkg::VALUE_W-1:0]    right_entry,
  output logic                                  less,
  output logic                                  at_slot,
  output logic                                  hit,
  output logic signed [sti_pkg::VALUE_W-1:0]    entry
);
  import sti_pkg::*;

  localparam int CNT_W = $clog2(DEPTH+1);

  logic signed [VALUE_W-1:0] entry_r;
  logic signed [VALUE_W-1:0] entry_nxt;
  logic                      occupied;

  assign occupied = (CNT_W'(IDX) < count);
  assign less     = occupied && (entry_r < ctl.value);
  // first cell that is not below the value: insertion point / first match
  assign at_slot  = !less && left_less;
  assign hit      = at_slot && occupied && (entry_r == ctl.value);
  assign entry    = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins_en && !less) begin
      entry_nxt = left_less ? ctl.value : left_entry;
    end else if (ctl.del_en && !less) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

/* hdl/sorted_table_insert_search_delete_core.sv */
// The accepting edge raises busy; the edge that ends the execute cycle raises out_valid.
// Items are taken only while busy is low; busy is high for the execute cycle in which
//   the row of cells compares the value in parallel and shifts the table in place.
// Results are shown for a single cycle on out_valid; the receiver cannot stall.
// Reset (rst_n low, synchronous) empties the table and clears busy and out_valid;
//   table entries themselves are not cleared, the count alone marks them stale.
module sorted_table_insert_search_delete_core #(
  parameter int TABLE_DEPTH = sti_pkg::DEFAULT_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sti_pkg::in_item_t  in_item,
  output logic               out_valid,
  output sti_pkg::out_item_t out_item
);
  import sti_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH+1);
  localparam int IDX_W = $clog2(TABLE_DEPTH);

  // control and operand registers
  logic                      busy_r;
  logic                      busy_nxt;
  logic [1:0]                cmd_r;
  logic signed [VALUE_W-1:0] value_r;
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  out_item_t                 out_item_r;
  out_item_t                 out_item_nxt;

  // cell row wiring
  cell_ctl_t                 ctl;
  logic [TABLE_DEPTH-1:0]    less;
  logic [TABLE_DEPTH-1:0]    at_slot;
  logic [TABLE_DEPTH-1:0]    hit;
  logic signed [VALUE_W-1:0] entry [TABLE_DEPTH];

  logic                      accept;
  logic                      full;
  logic                      found;
  logic [IDX_W-1:0]          slot_idx;

  assign accept = start && !busy_r;
  assign full   = (count_r == CNT_W'(TABLE_DEPTH));
  assign found  = |hit;

  // Encode the insertion point; at most one cell claims it.
  always_comb begin
    slot_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (at_slot[i]) begin
        slot_idx = slot_idx | IDX_W'(i);
      end
    end
  end

  // Broadcast the operand; shifting happens only in the execute cycle.
  always_comb begin
    ctl.value  = value_r;
    ctl.ins_en = busy_r && (cmd_r == CMD_INSERT) && !full;
    ctl.del_en = busy_r && (cmd_r == CMD_DELETE) && found;
  end

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      logic                      left_less;
      logic signed [VALUE_W-1:0] left_entry;
      logic signed [VALUE_W-1:0] right_entry;

      if (g == 0) begin : g_first
        assign left_less  = 1'b1;
        assign left_entry = entry[g];
      end else begin : g_mid
        assign left_less  = less[g-1];
        assign left_entry = entry[g-1];
      end

      if (g == TABLE_DEPTH-1) begin : g_last
        assign right_entry = entry[g];
      end else begin : g_inner
        assign right_entry = entry[g+1];
      end

      sti_cell #(
        .DEPTH (TABLE_DEPTH),
        .IDX   (g)
      ) u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .count       (count_r),
        .left_less   (left_less),
        .left_entry  (left_entry),
        .right_entry (right_entry),
        .less        (less[g]),
        .at_slot     (at_slot[g]),
        .hit         (hit[g]),
        .entry       (entry[g])
      );
    end
  endgenerate

  // Hold busy for the execute cycle, then drop it as the result goes out.
  always_comb begin
    busy_nxt      = busy_r ? 1'b0 : accept;
    out_valid_nxt = busy_r;
    count_nxt     = count_r;
    if (ctl.ins_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.del_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    out_item_nxt.status      = ST_ABSENT;
    out_item_nxt.position    = 4'd0;
    out_item_nxt.entry_count = 5'(count_nxt);
    case (cmd_r)
      CMD_INSERT: begin
        if (full) begin
          out_item_nxt.status = ST_FULL;
        end else begin
          out_item_nxt.status   = ST_OK;
          out_item_nxt.position = 4'(slot_idx);
        end
      end
      CMD_SEARCH, CMD_DELETE: begin
        if (found) begin
          out_item_nxt.status   = ST_OK;
          out_item_nxt.position = 4'(slot_idx);
        end
      end
      default: begin
        out_item_nxt.status = ST_ABSENT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  // payload registers: capture the item on accept, the result after execute
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_item.cmd;
      value_r <= in_item.value;
    end
    if (busy_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // The result strobe ends the execute cycle, so it never overlaps busy.
  a_strobe_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy_r)
    else $error("result strobe while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_single_slot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(at_slot))
    else $error("more than one cell claims the slot");

  a_count_reported: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.entry_count == 5'(count_r)))
    else $error("reported count differs from stored count");

  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && (cmd_r == CMD_INSERT) && full) |=> (count_r == CNT_W'(TABLE_DEPTH)))
    else $error("insert into a full table changed the count");

endmodule

/* test/tb_sorted_table_insert_search_delete_core.sv */
module tb_sorted_table_insert_search_delete_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sti_pkg::*;

  localparam int DEPTH = DEFAULT_DEPTH;
  // The fourth command code has no meaning; the block must treat it as a miss.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 880;
  // Longest quiet stretch of a correct run: the longest random gap, the execute
  // cycle and the wait for the result. Take it many times over.
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  // Shadow copy of the sorted table: predicts every result and holds the
  // predictions until the block shows them.
  class sorted_table_model;
    logic signed [VALUE_W-1:0] slots[DEPTH];
    int unsigned               fill;
    out_item_t                 expected[$];
    int unsigned               errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    // Apply one accepted command to the shadow table and queue its result.
    function void note_item(in_item_t it);
      out_item_t   res;
      int unsigned slot;
      res.status   = ST_ABSENT;
      res.position = '0;
      slot = 0;
      while (slot < fill && slots[slot] < it.value) slot++;
      case (it.cmd)
        CMD_INSERT: begin
          if (fill >= DEPTH) begin
            res.status = ST_FULL;
          end else begin
            for (int k = fill; k > slot; k--) slots[k] = slots[k-1];
            slots[slot]  = it.value;
            fill++;
            res.status   = ST_OK;
            res.position = slot[3:0];
          end
        end
        CMD_SEARCH, CMD_DELETE: begin
          if (slot < fill && slots[slot] == it.value) begin
            res.status   = ST_OK;
            res.position = slot[3:0];
            if (it.cmd == CMD_DELETE) begin
              for (int k = slot; k + 1 < fill; k++) slots[k] = slots[k+1];
              fill--;
            end
          end
        end
        default: ;
      endcase
      res.entry_count = fill[4:0];
      expected.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected.size() == 0) begin
        $error("unexpected result: status %0d position %0d entry_count %0d",
               got.status, got.position, got.entry_count);
        errors++;
        return;
      end
      want = expected.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.position !== want.position) begin
        $error("position: expected %0d, actual %0d", want.position, got.position);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", want.entry_count, got.entry_count);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  sorted_table_model shadow = new();

  // Gap control: bursts with no idling alternate with stretches of random gaps.
  bit burst_mode;
  // Random phase bias: grow fills the table, otherwise drain it.
  bit growing;

  sorted_table_insert_search_delete_core #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Monitor and watchdog. Everything here reads the values held before the
  // edge, so note the accepted command before checking any result.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) shadow.note_item(in_item);
      if (out_valid === 1'b1) shadow.check_result(out_item);
      if ((start && !busy) || out_valid === 1'b1) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic int unsigned draw_gap();
    if ($urandom_range(0, 99) < 5) burst_mode = !burst_mode;
    return burst_mode ? 0 : $urandom_range(0, 18);
  endfunction

  // Hold start high across back-to-back items; lower it only for a real gap.
  task automatic drive_item(input logic [1:0] cmd, input logic signed [VALUE_W-1:0] value);
    in_item_t    it;
    int unsigned gap;
    it.cmd   = cmd;
    it.value = value;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    // Wait for the accepting edge; busy is read before the edge updates it.
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Mix of values: mostly ones already stored (hits) or a narrow band with
  // many duplicates, some extremes, the rest anywhere in the 32-bit range.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int unsigned               roll;
    logic signed [VALUE_W-1:0] v;
    roll = $urandom_range(0, 99);
    if (roll < 40 && shadow.fill > 0) return shadow.slots[$urandom_range(0, shadow.fill - 1)];
    if (roll < 65) begin
      v = $urandom_range(0, 16);
      return v - 8;
    end
    if (roll < 72) begin
      case ($urandom_range(0, 3))
        0:       v = 32'sh7fff_ffff;
        1:       v = 32'sh8000_0000;
        2:       v = '0;
        default: v = '1;
      endcase
      return v;
    end
    v = $urandom;
    return v;
  endfunction

  function automatic logic [1:0] pick_cmd();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return CMD_UNUSED;
    if (roll < 25) return CMD_SEARCH;
    if (growing) return (roll < 82) ? CMD_INSERT : CMD_DELETE;
    return (roll < 82) ? CMD_DELETE : CMD_INSERT;
  endfunction

  initial begin
    int unsigned counted;
    logic [1:0]  cmd;

    rst_n      = 1'b0;
    start      = 1'b0;
    in_item    = '0;
    burst_mode = 1'b0;
    growing    = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: commands on an empty table, the unused code, the extremes
    // of the value range and a duplicate, hits and a miss.
    drive_item(CMD_SEARCH, 32'sd0);
    drive_item(CMD_DELETE, 32'sd0);
    drive_item(CMD_UNUSED, 32'sd7);
    drive_item(CMD_INSERT, 32'sh7fff_ffff);
    drive_item(CMD_INSERT, 32'sh8000_0000);
    drive_item(CMD_INSERT, 32'sd0);
    drive_item(CMD_INSERT, 32'sd0);
    drive_item(CMD_SEARCH, 32'sd0);
    drive_item(CMD_SEARCH, 32'sh7fff_ffff);
    drive_item(CMD_SEARCH, 32'sh8000_0000);
    drive_item(CMD_DELETE, 32'sd0);
    drive_item(CMD_DELETE, 32'sd5);
    // Fill the table to its limit; the last insert must be refused.
    repeat (DEPTH - 3 + 1) drive_item(CMD_INSERT, pick_value());

    // Random: sweep the count between empty and full so that both limits
    // are met repeatedly. Ignored commands do not count.
    growing = 1'b0;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (shadow.fill >= DEPTH) growing = 1'b0;
      else if (shadow.fill == 0) growing = 1'b1;
      else if ($urandom_range(0, 99) < 3) growing = !growing;
      cmd = pick_cmd();
      drive_item(cmd, pick_value());
      if (cmd != CMD_UNUSED) counted++;
    end

    @(negedge clk);
    start <= 1'b0;

    // Drain every outstanding result, then give any stray result time to show.
    while (shadow.expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (shadow.errors == 0 && shadow.expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
